@@ rtl/core/humidity_temp_frame_decoder_assert.svh @@
// Assertion macros shared by the frame decoder RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define HTFD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/htfd_pkg.sv @@
// Package for the humidity/temperature frame decoder.
// Holds beat types, frame byte positions, CRC-8 and scaling functions.
// No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [14:0] TEMP_GAIN   = 15'd17500;
    localparam logic [14:0] HUMI_GAIN   = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] WORD_MAX    = 17'd65535;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic               temp_crc_ok;
        logic               humi_crc_ok;
        logic               frame_ok;
    } out_beat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(gain * raw / 65535): take the quotient by 65536, then correct by one
    function automatic logic [14:0] centi_scale(input logic [15:0] raw, input logic [14:0] gain);
        logic [30:0] prod;
        logic [14:0] q;
        logic [16:0] rem;
        prod = 31'(raw) * 31'(gain);
        q    = prod[30:16];
        rem  = 17'(prod[15:0]) + 17'(q);
        if (rem >= WORD_MAX)
        begin
            q = q + 15'd1;
        end
        return q;
    endfunction

endpackage

@@ rtl/core/humidity_temp_frame_decoder.sv @@
// Humidity/temperature frame decoder top level.
// A byte beat is held in the input register, which feeds the CRC/scaling logic; a frame's
// last byte loads the result register, which presents the result beat. Throughput: one byte
// beat per cycle, set by both registers, unless a held result beat stalls the last byte.
// Reset (rst_n low, asynchronous) empties both registers and restarts at byte 0.
// Depends on htfd_pkg and humidity_temp_frame_decoder_assert.svh.
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_assert.svh"

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_beat_t  byte_data,
    output logic      meas_valid,
    input  logic      meas_stall,
    output out_beat_t meas_data
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_beat_t  s1_data_reg;
    pos_t      pos_reg;
    pos_t      pos_next;
    logic [7:0]  crc_reg;
    logic [7:0]  crc_next;
    logic [15:0] t_raw_reg;
    logic [15:0] t_raw_next;
    logic [15:0] h_raw_reg;
    logic [15:0] h_raw_next;
    logic        t_ok_reg;
    logic        t_ok_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_beat_t   out_data_reg;
    out_beat_t   out_data_next;

    pos_t        pos_cur;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_upd;
    logic        is_last;
    logic        advance;
    logic        load;
    logic        humi_ok;
    logic [14:0] t_scaled;
    logic [14:0] h_scaled;

    assign pos_cur  = s1_data_reg.frame_start ? POS_T_HI : pos_reg;
    assign is_last  = (pos_cur == POS_H_CRC);
    assign advance  = s1_valid_reg && (!is_last || !out_valid_reg || !meas_stall);
    assign byte_stall = s1_valid_reg && !advance;
    assign load     = byte_valid && !byte_stall;

    assign crc_seed = (pos_cur == POS_T_HI || pos_cur == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_upd  = crc8_byte(crc_seed, s1_data_reg.rx_byte);
    assign humi_ok  = (crc_reg == s1_data_reg.rx_byte);
    assign t_scaled = centi_scale(t_raw_reg, TEMP_GAIN);
    assign h_scaled = centi_scale(h_raw_reg, HUMI_GAIN);

    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        t_raw_next = t_raw_reg;
        h_raw_next = h_raw_reg;
        t_ok_next  = t_ok_reg;
        if (advance)
        begin
            case (pos_cur)
                POS_T_HI:
                begin
                    crc_next   = crc_upd;
                    t_raw_next = {s1_data_reg.rx_byte, t_raw_reg[7:0]};
                    pos_next   = POS_T_LO;
                end
                POS_T_LO:
                begin
                    crc_next   = crc_upd;
                    t_raw_next = {t_raw_reg[15:8], s1_data_reg.rx_byte};
                    pos_next   = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_ok_next = (crc_reg == s1_data_reg.rx_byte);
                    crc_next  = CRC_INIT;
                    pos_next  = POS_H_HI;
                end
                POS_H_HI:
                begin
                    crc_next   = crc_upd;
                    h_raw_next = {s1_data_reg.rx_byte, h_raw_reg[7:0]};
                    pos_next   = POS_H_LO;
                end
                POS_H_LO:
                begin
                    crc_next   = crc_upd;
                    h_raw_next = {h_raw_reg[15:8], s1_data_reg.rx_byte};
                    pos_next   = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_T_HI;
                end
                default:
                begin
                    pos_next = POS_T_HI;
                end
            endcase
        end
    end

    always_comb
    begin
        out_data_next.temperature_centi = $signed(t_scaled - TEMP_OFFSET);
        out_data_next.humidity_centi    = h_scaled[13:0];
        out_data_next.temp_crc_ok       = t_ok_reg;
        out_data_next.humi_crc_ok       = humi_ok;
        out_data_next.frame_ok          = t_ok_reg && humi_ok;

        if (advance && is_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!meas_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            t_raw_reg     <= '0;
            h_raw_reg     <= '0;
            t_ok_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            t_raw_reg     <= t_raw_next;
            h_raw_reg     <= h_raw_next;
            t_ok_reg      <= t_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_data_reg <= byte_data;
        end
        if (advance && is_last)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign meas_valid = out_valid_reg;
    assign meas_data  = out_data_reg;

    `HTFD_ASSERT_IMPLIES(a_frame_ok, clk, rst_n, out_valid_reg, out_data_reg.frame_ok == (out_data_reg.temp_crc_ok && out_data_reg.humi_crc_ok))
    `HTFD_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, byte_stall, s1_valid_reg && out_valid_reg && meas_stall && is_last)
    `HTFD_ASSERT_NEXT(a_restart, clk, rst_n, advance && is_last, pos_reg == POS_T_HI && crc_reg == CRC_INIT && out_valid_reg)

endmodule

@@ test/testbench.sv @@
// Self-checking bench for humidity_temp_frame_decoder: directed and random frame traffic.
// Predicts each measurement beat from the byte beats it accepts; depends on htfd_pkg and the DUT.
`timescale 1ns / 1ps

module testbench;
    import htfd_pkg::*;

    localparam int RANDOM_BYTES   = 730;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_beat_t  byte_data = '0;
    logic      meas_valid;
    logic      meas_stall = 1'b0;
    out_beat_t meas_data;

    humidity_temp_frame_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas_data  (meas_data)
    );

    always #2 clk = ~clk;

    pos_t       next_slot = POS_T_HI;
    logic [7:0] crc_run = CRC_INIT;
    logic [15:0] temp_word = '0;
    logic [15:0] humi_word = '0;
    logic       temp_pass = 1'b0;
    out_beat_t  pending_meas[$];

    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int stall_hold = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int bad_frames = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    out_beat_t want;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function automatic int to_centi(input logic [15:0] raw, input int gain);
        longint p;
        p = longint'(gain) * longint'(raw);
        return int'(p / 65535);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 94)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic decode_byte(input in_beat_t beat);
        out_beat_t  res;
        logic [7:0] b;
        pos_t       at;
        logic       humi_pass;
        b  = beat.rx_byte;
        at = beat.frame_start ? POS_T_HI : next_slot;
        case (at)
            POS_T_HI:
            begin
                crc_run = crc_step(CRC_INIT, b);
                temp_word[15:8] = b;
                next_slot = POS_T_LO;
            end
            POS_T_LO:
            begin
                crc_run = crc_step(crc_run, b);
                temp_word[7:0] = b;
                next_slot = POS_T_CRC;
            end
            POS_T_CRC:
            begin
                temp_pass = (crc_run == b);
                crc_run = CRC_INIT;
                next_slot = POS_H_HI;
            end
            POS_H_HI:
            begin
                crc_run = crc_step(CRC_INIT, b);
                humi_word[15:8] = b;
                next_slot = POS_H_LO;
            end
            POS_H_LO:
            begin
                crc_run = crc_step(crc_run, b);
                humi_word[7:0] = b;
                next_slot = POS_H_CRC;
            end
            default:
            begin
                humi_pass = (crc_run == b);
                crc_run = CRC_INIT;
                next_slot = POS_T_HI;
                res.temperature_centi = 15'(to_centi(temp_word, int'(TEMP_GAIN))
                                            - int'(TEMP_OFFSET));
                res.humidity_centi = 14'(to_centi(humi_word, int'(HUMI_GAIN)));
                res.temp_crc_ok = temp_pass;
                res.humi_crc_ok = humi_pass;
                res.frame_ok = temp_pass & humi_pass;
                pending_meas.push_back(res);
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] value, input logic start);
        in_beat_t beat;
        int       gap;
        beat.rx_byte = value;
        beat.frame_start = start;
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data <= beat;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        decode_byte(beat);
        bytes_sent++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
            byte_data <= in_beat_t'(9'($urandom));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [7:0] t_crc,
                              input logic [15:0] h, input logic [7:0] h_crc,
                              input logic start);
        send_byte(t[15:8], start);
        send_byte(t[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    task automatic test_scale_extremes();
        send_frame(16'h0000, word_crc(16'h0000), 16'hFFFF, word_crc(16'hFFFF), 1'b1);
        send_frame(16'hFFFF, word_crc(16'hFFFF), 16'h0000, word_crc(16'h0000), 1'b0);
    endtask

    task automatic test_crc_errors();
        send_frame(16'h6A3C, ~word_crc(16'h6A3C), 16'h8000, word_crc(16'h8000), 1'b1);
    endtask

    task automatic test_resync();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_frame(16'h1234, word_crc(16'h1234), 16'h5555, word_crc(16'h5555) ^ 8'h01,
                   1'b1);
    endtask

    function automatic logic [15:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            return 16'h0000;
        end
        if (roll < 10)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_crc(input logic [15:0] w);
        if ($urandom_range(0, 99) < 85)
        begin
            return word_crc(w);
        end
        return word_crc(w) ^ 8'($urandom_range(1, 255));
    endfunction

    task automatic test_random_traffic();
        int          stop_at;
        int          section;
        int          noise;
        logic [15:0] t;
        logic [15:0] h;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            section = bytes_sent / 90;
            gaps_on = (section % 4) != 1;
            stalls_on = (section % 4) != 2;
            if ($urandom_range(0, 99) < 12)
            begin
                noise = $urandom_range(1, 5);
                repeat (noise)
                begin
                    send_byte(8'($urandom), $urandom_range(0, 99) < 20);
                end
            end
            t = pick_word();
            h = pick_word();
            send_frame(t, pick_crc(t), h, pick_crc(h), 1'($urandom_range(0, 1)));
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || !stalls_on)
        begin
            meas_stall <= 1'b0;
            stall_hold = 0;
        end
        else if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
            meas_stall <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    meas_stall <= 1'b1;
                    stall_hold = $urandom_range(0, 2);
                end
                4:
                begin
                    meas_stall <= 1'b1;
                    stall_hold = $urandom_range(10, 40);
                end
                default:
                begin
                    meas_stall <= 1'b0;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && meas_valid && !meas_stall)
        begin
            beats_checked++;
            if (!meas_data.frame_ok)
            begin
                bad_frames++;
            end
            if (pending_meas.size() == 0)
            begin
                $error("unexpected measurement beat");
                fail_count++;
            end
            else
            begin
                want = pending_meas.pop_front();
                if (meas_data.temperature_centi !== want.temperature_centi)
                begin
                    $error("temperature_centi: expected %0d, got %0d",
                           want.temperature_centi, meas_data.temperature_centi);
                    fail_count++;
                end
                if (meas_data.humidity_centi !== want.humidity_centi)
                begin
                    $error("humidity_centi: expected %0d, got %0d",
                           want.humidity_centi, meas_data.humidity_centi);
                    fail_count++;
                end
                if (meas_data.temp_crc_ok !== want.temp_crc_ok)
                begin
                    $error("temp_crc_ok: expected %0b, got %0b",
                           want.temp_crc_ok, meas_data.temp_crc_ok);
                    fail_count++;
                end
                if (meas_data.humi_crc_ok !== want.humi_crc_ok)
                begin
                    $error("humi_crc_ok: expected %0b, got %0b",
                           want.humi_crc_ok, meas_data.humi_crc_ok);
                    fail_count++;
                end
                if (meas_data.frame_ok !== want.frame_ok)
                begin
                    $error("frame_ok: expected %0b, got %0b",
                           want.frame_ok, meas_data.frame_ok);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (meas_valid && !meas_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_scale_extremes();
        test_crc_errors();
        test_resync();
        test_random_traffic();

        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_meas.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d byte beats; checked %0d measurement beats, %0d with a CRC error.",
                 bytes_sent, beats_checked, bad_frames);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
